// File: hdl/door_contact_event_tracker_defines.svh
// Assertion macros used by the checker module dcet_checker.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef DOOR_CONTACT_EVENT_TRACKER_DEFINES_SVH
`define DOOR_CONTACT_EVENT_TRACKER_DEFINES_SVH

// General property, checked on every rising clock edge outside reset.
`define DCET_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A signal holds its value in the cycle after a condition.
`define DCET_ASSERT_HOLD(lbl, cond, sig, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

// File: hdl/dcet_pkg.sv
`default_nettype none

package dcet_pkg;

   // Default number of door areas.
   localparam int DEF_AREAS = 4;
   // Input channels that carry a level; a mapped channel at or above this reads low.
   localparam int CHANNELS = 8;
   // Areas that have contact bits in the configuration registers and result fields.
   localparam int PACK_AREAS = 4;
   localparam int CSR_DW = 24;
   localparam int CSR_IW = 2;
   localparam int CNT_W = 16;

   // Operation codes.
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_SET_STATUS = 3'd1;
   localparam logic [2:0] OP_CLR_OPENED = 3'd2;
   localparam logic [2:0] OP_CLR_CLOSED = 3'd3;
   localparam logic [2:0] OP_RESYNC     = 3'd4;
   localparam logic [2:0] OP_LAST_QUERY = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] REG_AREA_COUNT    = 2'd0;
   localparam logic [CSR_IW-1:0] REG_SWITCH_ENABLE = 2'd1;
   localparam logic [CSR_IW-1:0] REG_INVERT_MASK   = 2'd2;
   localparam logic [CSR_IW-1:0] REG_CHANNEL_MAP   = 2'd3;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] channel_levels;
      logic [7:0] channel_changed;
      logic       in_application;
      logic [1:0] area;
      logic       closed_value;
   } req_type;

   typedef struct packed {
      logic [PACK_AREAS-1:0] door_closed;
      logic [PACK_AREAS-1:0] opened_flags;
      logic [PACK_AREAS-1:0] closed_flags;
      logic [PACK_AREAS-1:0] counting_marks;
      logic [PACK_AREAS-1:0] opened_edges;
      logic [PACK_AREAS-1:0] closed_edges;
      logic                  accepted;
      logic                  contacts_changed;
      logic                  all_closed;
      logic                  last_closed;
      logic [CNT_W-1:0]      opened_count;
      logic [CNT_W-1:0]      closed_count;
   } rsp_type;

   // Static per-lane setup taken from the configuration registers.
   typedef struct packed {
      logic       in_use;
      logic       sel;
      logic [1:0] enable;
      logic [1:0] invert;
      logic [2:0] chan0;
      logic [2:0] chan1;
   } lane_cfg_type;

   // Decoded request broadcast to every lane.
   typedef struct packed {
      logic       accept;
      logic       tick;
      logic       set_ok;
      logic       clr_opened;
      logic       clr_closed;
      logic       resync;
      logic       in_app;
      logic       closed_value;
      logic       synced;
      logic       first_check;
      logic       any_changed;
      logic [7:0] levels;
      logic [7:0] changed;
   } lane_ctrl_type;

   // What one lane reports: next state values and edges of this request.
   typedef struct packed {
      logic             chg_hit;
      logic             closed;
      logic             door_ok;
      logic             opened_edge;
      logic             closed_edge;
      logic             opened_flag;
      logic             closed_flag;
      logic             mark;
      logic [CNT_W-1:0] opened_cnt;
      logic [CNT_W-1:0] closed_cnt;
   } lane_res_type;

endpackage

`default_nettype wire

// File: hdl/dcet_lane.sv
`default_nettype none

module dcet_lane
   import dcet_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lane_cfg_type  cfg,
   input  wire lane_ctrl_type ctrl,
   output lane_res_type       res
);

   logic             status_ff, status_in;
   logic             prev_ff, prev_in;
   logic             oflag_ff, oflag_in;
   logic             cflag_ff, cflag_in;
   logic             mark_ff, mark_in;
   logic [CNT_W-1:0] ocnt_ff, ocnt_in;
   logic [CNT_W-1:0] ccnt_ff, ccnt_in;

   logic ch0_ok, ch1_ok;
   logic lvl0, lvl1;
   logic cl0, cl1;
   logic any_switch;
   logic sample_closed;
   logic run_edges;
   logic opened, closed;

   // Contact levels; a channel outside the populated range reads low and never changed.
   assign ch0_ok = int'(cfg.chan0) < CHANNELS;
   assign ch1_ok = int'(cfg.chan1) < CHANNELS;
   assign lvl0   = ch0_ok & ctrl.levels[cfg.chan0];
   assign lvl1   = ch1_ok & ctrl.levels[cfg.chan1];
   assign cl0    = cfg.invert[0] ? lvl0 : ~lvl0;
   assign cl1    = cfg.invert[1] ? lvl1 : ~lvl1;

   // The door reads closed only when every enabled contact reads closed.
   assign any_switch    = |cfg.enable;
   assign sample_closed = (~cfg.enable[0] | cl0) & (~cfg.enable[1] | cl1);

   // This lane's contribution to the contacts-ever-changed summary.
   assign res.chg_hit = cfg.in_use &
                        ((cfg.enable[0] & ch0_ok & ctrl.changed[cfg.chan0]) |
                         (cfg.enable[1] & ch1_ok & ctrl.changed[cfg.chan1]));

   // Status update, edge detection, flags and counters.
   always_comb begin
      status_in = status_ff;
      if (ctrl.tick && cfg.in_use && any_switch && (!ctrl.synced || ctrl.any_changed)) begin
         status_in = sample_closed;
      end
      if (ctrl.resync && cfg.in_use && any_switch) begin
         status_in = sample_closed;
      end
      if (ctrl.set_ok && cfg.sel) begin
         status_in = ctrl.closed_value;
      end

      run_edges = (ctrl.tick || ctrl.set_ok) && cfg.in_use && (prev_ff != status_in);
      opened    = run_edges && prev_ff;
      closed    = run_edges && !prev_ff;
      prev_in   = run_edges ? status_in : prev_ff;

      oflag_in = oflag_ff | (opened & ~ctrl.first_check);
      if (ctrl.clr_opened && cfg.in_use) begin
         oflag_in = 1'b0;
      end
      cflag_in = cflag_ff | closed;
      if (ctrl.clr_closed && cfg.in_use) begin
         cflag_in = 1'b0;
      end
      mark_in = mark_ff | (opened & ctrl.in_app);
      ocnt_in = (opened && !ctrl.first_check) ? ocnt_ff + CNT_W'(1) : ocnt_ff;
      ccnt_in = closed ? ccnt_ff + CNT_W'(1) : ccnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= 1'b1;
         prev_ff   <= 1'b1;
         oflag_ff  <= 1'b0;
         cflag_ff  <= 1'b0;
         mark_ff   <= 1'b0;
         ocnt_ff   <= '0;
         ccnt_ff   <= '0;
      end else if (ctrl.accept) begin
         status_ff <= status_in;
         prev_ff   <= prev_in;
         oflag_ff  <= oflag_in;
         cflag_ff  <= cflag_in;
         mark_ff   <= mark_in;
         ocnt_ff   <= ocnt_in;
         ccnt_ff   <= ccnt_in;
      end
   end

   assign res.closed      = status_in;
   assign res.door_ok     = ~cfg.in_use | status_in;
   assign res.opened_edge = opened;
   assign res.closed_edge = closed;
   assign res.opened_flag = oflag_in;
   assign res.closed_flag = cflag_in;
   assign res.mark        = mark_in;
   assign res.opened_cnt  = ocnt_in;
   assign res.closed_cnt  = ccnt_in;

endmodule

`default_nettype wire

// File: hdl/dcet_merge.sv
`default_nettype none

module dcet_merge
   import dcet_pkg::*;
#(
   parameter int AREAS = DEF_AREAS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data,
   input  wire lane_res_type lane_res [AREAS],
   output lane_ctrl_type     ctrl
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    synced_ff, synced_in;
   logic    first_ff, first_in;
   logic    aac_ff, aac_in;

   logic                  accept;
   logic                  any_changed;
   logic                  all_ok;
   logic                  any_opened;
   logic                  is_tick, is_set, is_clr_o, is_clr_c, is_resync, is_query;
   logic                  last;
   logic [AREAS-1:0]      hit_vec, ok_vec, oedge_vec;
   logic [PACK_AREAS-1:0] closed_bits, oflag_bits, cflag_bits, mark_bits;
   logic [PACK_AREAS-1:0] oedge_bits, cedge_bits;
   logic [CNT_W-1:0]      ocnt_sel, ccnt_sel;

   // The result register frees up in the same cycle it is taken.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // Gather the per-lane findings.
   for (genvar g = 0; g < AREAS; g++) begin : g_gather
      assign hit_vec[g]   = lane_res[g].chg_hit;
      assign ok_vec[g]    = lane_res[g].door_ok;
      assign oedge_vec[g] = lane_res[g].opened_edge;
   end

   assign any_changed = |hit_vec;
   assign all_ok      = &ok_vec;
   assign any_opened  = |oedge_vec;

   // Only the first few areas appear in the result fields.
   for (genvar g = 0; g < PACK_AREAS; g++) begin : g_pack
      if (g < AREAS) begin : g_lane
         assign closed_bits[g] = lane_res[g].closed;
         assign oflag_bits[g]  = lane_res[g].opened_flag;
         assign cflag_bits[g]  = lane_res[g].closed_flag;
         assign mark_bits[g]   = lane_res[g].mark;
         assign oedge_bits[g]  = lane_res[g].opened_edge;
         assign cedge_bits[g]  = lane_res[g].closed_edge;
      end else begin : g_none
         assign closed_bits[g] = 1'b0;
         assign oflag_bits[g]  = 1'b0;
         assign cflag_bits[g]  = 1'b0;
         assign mark_bits[g]   = 1'b0;
         assign oedge_bits[g]  = 1'b0;
         assign cedge_bits[g]  = 1'b0;
      end
   end

   // Counter readout for the requested area.
   always_comb begin
      ocnt_sel = '0;
      ccnt_sel = '0;
      for (int i = 0; i < AREAS; i++) begin
         if (int'(req_data.area) == i) begin
            ocnt_sel = lane_res[i].opened_cnt;
            ccnt_sel = lane_res[i].closed_cnt;
         end
      end
   end

   // Operation decode.
   always_comb begin
      is_tick   = 1'b0;
      is_set    = 1'b0;
      is_clr_o  = 1'b0;
      is_clr_c  = 1'b0;
      is_resync = 1'b0;
      is_query  = 1'b0;
      unique case (req_data.op)
         OP_TICK:       is_tick   = 1'b1;
         OP_SET_STATUS: is_set    = 1'b1;
         OP_CLR_OPENED: is_clr_o  = 1'b1;
         OP_CLR_CLOSED: is_clr_c  = 1'b1;
         OP_RESYNC:     is_resync = 1'b1;
         OP_LAST_QUERY: is_query  = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      ctrl.accept       = accept;
      ctrl.tick         = is_tick;
      ctrl.set_ok       = is_set & ~any_changed;
      ctrl.clr_opened   = is_clr_o;
      ctrl.clr_closed   = is_clr_c;
      ctrl.resync       = is_resync;
      ctrl.in_app       = req_data.in_application;
      ctrl.closed_value = req_data.closed_value;
      ctrl.synced       = synced_ff;
      ctrl.first_check  = first_ff;
      ctrl.any_changed  = any_changed;
      ctrl.levels       = req_data.channel_levels;
      ctrl.changed      = req_data.channel_changed;
   end

   // Shared state and the last-door-closed report.
   always_comb begin
      synced_in = synced_ff | is_tick | is_resync;
      first_in  = first_ff & ~(is_tick | ctrl.set_ok);
      aac_in    = aac_ff & ~any_opened;
      last      = 1'b0;
      if (is_query && all_ok && !aac_ff) begin
         aac_in = 1'b1;
         last   = 1'b1;
      end
   end

   // Result assembly.
   always_comb begin
      rsp_data_in.door_closed      = closed_bits;
      rsp_data_in.opened_flags     = oflag_bits;
      rsp_data_in.closed_flags     = cflag_bits;
      rsp_data_in.counting_marks   = mark_bits;
      rsp_data_in.opened_edges     = oedge_bits;
      rsp_data_in.closed_edges     = cedge_bits;
      rsp_data_in.accepted         = ctrl.set_ok;
      rsp_data_in.contacts_changed = any_changed;
      rsp_data_in.all_closed       = all_ok;
      rsp_data_in.last_closed      = last;
      rsp_data_in.opened_count     = ocnt_sel;
      rsp_data_in.closed_count     = ccnt_sel;
      rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         synced_ff    <= 1'b0;
         first_ff     <= 1'b1;
         aac_ff       <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            synced_ff <= synced_in;
            first_ff  <= first_in;
            aac_ff    <= aac_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/door_contact_event_tracker.sv
// Door contact event tracker: keeps the open/closed state of up to AREAS doors, each
// watched by up to two contacts that map to input channels with their own polarity.
// Every request (tick, set status, flag clears, resync, last-closed query) yields
// exactly one response that shows the state after the request and the counters of
// the area named in it. Each area has its own lane, and all lanes evaluate a request
// together and combinationally into the response register, so a new request is taken
// every cycle; the single response register is the only buffer, and req_ready drops
// only while a response waits and rsp_ready is low. Configuration writes are taken
// every cycle (csr_ready stays high) and belong in idle periods. Reset is immediate;
// there is no clearing pass.
`default_nettype none

module door_contact_event_tracker
   import dcet_pkg::*;
#(
   parameter int AREAS = DEF_AREAS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   logic [2:0]        area_count_ff;
   logic [7:0]        switch_enable_ff;
   logic [7:0]        invert_mask_ff;
   logic [CSR_DW-1:0] channel_map_ff;

   lane_cfg_type  lane_cfg [AREAS];
   lane_res_type  lane_res [AREAS];
   lane_ctrl_type ctrl;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         area_count_ff    <= 3'd1;
         switch_enable_ff <= '0;
         invert_mask_ff   <= '0;
         channel_map_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_AREA_COUNT:    area_count_ff    <= csr_wdata[2:0];
            REG_SWITCH_ENABLE: switch_enable_ff <= csr_wdata[7:0];
            REG_INVERT_MASK:   invert_mask_ff   <= csr_wdata[7:0];
            REG_CHANNEL_MAP:   channel_map_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Per-area lanes; areas beyond the register fields have no contacts.
   for (genvar g = 0; g < AREAS; g++) begin : g_lane
      assign lane_cfg[g].in_use = int'(area_count_ff) > g;
      assign lane_cfg[g].sel    = int'(req_data.area) == g;
      if (g < PACK_AREAS) begin : g_cfg
         assign lane_cfg[g].enable = switch_enable_ff[2*g +: 2];
         assign lane_cfg[g].invert = invert_mask_ff[2*g +: 2];
         assign lane_cfg[g].chan0  = channel_map_ff[6*g +: 3];
         assign lane_cfg[g].chan1  = channel_map_ff[6*g+3 +: 3];
      end else begin : g_nocfg
         assign lane_cfg[g].enable = 2'b00;
         assign lane_cfg[g].invert = 2'b00;
         assign lane_cfg[g].chan0  = 3'd0;
         assign lane_cfg[g].chan1  = 3'd0;
      end

      dcet_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (lane_cfg[g]),
         .ctrl  (ctrl),
         .res   (lane_res[g])
      );
   end

   // Merge the lane findings, hold shared state and drive the response.
   dcet_merge #(
      .AREAS (AREAS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .lane_res  (lane_res),
      .ctrl      (ctrl)
   );

endmodule

`default_nettype wire

// File: hdl/dcet_checker.sv
`default_nettype none

`include "door_contact_event_tracker_defines.svh"

module dcet_checker
   import dcet_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A stalled response keeps its contents.
   `DCET_ASSERT_HOLD(a_rsp_hold, rsp_valid && !rsp_ready, rsp_data, "stalled response changed")

   // With the response register empty a request is always taken.
   `DCET_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "request stalled with no response pending")

   // Every accepted request yields a response in the next cycle.
   `DCET_ASSERT(a_rsp_follows, req_valid && req_ready |=> rsp_valid, "accepted request gave no response")

   // An area cannot open and close within one request.
   `DCET_ASSERT(a_edge_excl, rsp_valid |-> ((rsp_data.opened_edges & rsp_data.closed_edges) == '0), "area opened and closed together")

   // A last-closed report implies that all doors are closed.
   `DCET_ASSERT(a_last_closed, rsp_valid && rsp_data.last_closed |-> rsp_data.all_closed, "last closed without all closed")

endmodule

bind door_contact_event_tracker dcet_checker u_dcet_checker (.*);

`default_nettype wire
